FILE: hw/rtl/ggm_tree_prf_eval_defines.svh
// Assertion macros used by the RTL file ggm_tree_prf_eval.sv.
`ifndef GGM_TREE_PRF_EVAL_DEFINES_SVH
`define GGM_TREE_PRF_EVAL_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define GGM_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define GGM_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: hw/rtl/ggm_pkg.sv
package ggm_pkg;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY,
		ST_ROUND,
		ST_DONE
	} ggm_state_t;

	localparam int unsigned TagW   = 32;
	localparam int unsigned LevelW = 6;
	localparam logic [3:0]  LastRound = 4'd10;

	// AES forward S-box.
	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte j of a 128-bit block, byte 0 in the top bits.
	function automatic logic [7:0] byte_of(input logic [127:0] b, input int j);
		return b[127 - 8*j -: 8];
	endfunction

	// One encryption round without the round key; mix selects MixColumns.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				t[c*4 + j] = sbox(byte_of(s, ((c + j) % 4) * 4 + j));
			end
		end
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				x = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int j = 0; j < 16; j++) begin
			r[127 - 8*j -: 8] = t[j];
		end
		return r;
	endfunction

	// Next round key from the current one.
	function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

FILE: hw/rtl/ggm_tree_prf_eval.sv
// Channel  | Signals                                  | Handshake
// request  | key_hi, key_lo, tag, start_level         | start && !busy
// result   | out_hi, out_lo                           | done, one cycle
//
// One AES-128 round unit, with on-the-fly key expansion, is shared by every level.
// Each level runs an initial key add (ST_KEY) and then 10 rounds (ST_ROUND); a request
// with start_level >= TREE_DEPTH goes from ST_KEY straight to ST_DONE.
// busy is high from acceptance until the done cycle ends; reset clears it.
// The receiver cannot stall: the result is shown for one cycle only.
`include "ggm_tree_prf_eval_defines.svh"

module ggm_tree_prf_eval import ggm_pkg::*; #(
	parameter int unsigned TREE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       key_hi,
	input  logic [63:0]       key_lo,
	input  logic [TagW-1:0]   tag,
	input  logic [LevelW-1:0] start_level,
	output logic              done,
	output logic [63:0]       out_hi,
	output logic [63:0]       out_lo
);

	localparam logic [LevelW-1:0] Depth = LevelW'(TREE_DEPTH);

	ggm_state_t state_q, state_d;
	logic [127:0] key_q;     // key of the current level
	logic [127:0] rkey_q;    // running round key
	logic [127:0] blk_q;     // cipher state
	logic [TagW-1:0]   tag_q;
	logic [LevelW-1:0] lvl_q;
	logic [3:0]   round_q;
	logic [7:0]   rcon_q;

	logic accept;
	logic [127:0] rk_next, rnd_out, plain;
	logic bit_sel;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign out_hi = key_q[127:64];
	assign out_lo = key_q[63:0];

	// Shared round unit.
	assign rk_next = next_rkey(rkey_q, rcon_q);
	assign rnd_out = aes_round(blk_q, round_q != LastRound) ^ rk_next;
	// Bit 31 - level of the tag; for a five-bit level that is its complement.
	assign bit_sel = tag_q[~lvl_q[4:0]];
	assign plain   = bit_sel ? {8{16'h0100}} : {8{16'h0001}};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_KEY;
			ST_KEY:   state_d = (lvl_q >= Depth) ? ST_DONE : ST_ROUND;
			ST_ROUND: if (round_q == LastRound) state_d = ST_KEY;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				key_q <= {key_hi, key_lo};
				tag_q <= tag;
				lvl_q <= start_level;
			end
			ST_KEY: begin
				blk_q   <= plain ^ key_q;
				rkey_q  <= key_q;
				rcon_q  <= 8'h01;
				round_q <= 4'd1;
			end
			ST_ROUND: begin
				blk_q   <= rnd_out;
				rkey_q  <= rk_next;
				rcon_q  <= xtime(rcon_q);
				round_q <= round_q + 4'd1;
				if (round_q == LastRound) begin
					key_q <= rnd_out;
					lvl_q <= lvl_q + LevelW'(1);
				end
			end
			default: ;
		endcase
	end

	`GGM_ASSERT_IMP(a_round_range, clk, arst_n, state_q == ST_ROUND,
		round_q >= 4'd1 && round_q <= LastRound, "round out of range")
	`GGM_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy && !done,
		"accept did not raise busy")
	`GGM_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done && !busy,
		"done not single cycle")

endmodule

FILE: tb/testbench.sv
module testbench import ggm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [63:0]       key_hi;
		logic [63:0]       key_lo;
		logic [TagW-1:0]   tag;
		logic [LevelW-1:0] level;
	} prf_request_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} prf_key_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [63:0]       key_hi;
	logic [63:0]       key_lo;
	logic [TagW-1:0]   tag;
	logic [LevelW-1:0] start_level;
	logic              done;
	logic [63:0]       out_hi;
	logic [63:0]       out_lo;

	prf_request_t pending_requests[$];
	prf_key_t     expected_keys[$];
	int unsigned  error_count;
	int unsigned  results_seen;
	int unsigned  cycle_count;
	int unsigned  gap_left;
	int unsigned  bottom_level_count;
	bit           drain_hold;
	bit           stimulus_done;

	ggm_tree_prf_eval #(.TREE_DEPTH(DEPTH)) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key_hi      (key_hi),
		.key_lo      (key_lo),
		.tag         (tag),
		.start_level (start_level),
		.done        (done),
		.out_hi      (out_hi),
		.out_lo      (out_lo)
	);

	// Free-running clock and a single reset pulse at the start.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// AES S-box computed from the field inverse and the affine map.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] subst_byte(input logic [7:0] x);
		logic [7:0] inv;
		logic [7:0] y;
		// x^254 is the multiplicative inverse, with zero mapping to zero.
		inv = 8'h01;
		for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
		y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
		return y;
	endfunction

	logic [7:0] sbox_lut [256];
	initial begin
		for (int i = 0; i < 256; i++) sbox_lut[i] = subst_byte(8'(i));
	end

	// One block of AES-128 under the given key; byte 0 is in the top bits.
	function automatic logic [127:0] encrypt_block(input logic [127:0] key,
			input logic [127:0] plain);
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] rk [176];
		logic [7:0] w [4];
		logic [7:0] rc, f, a0, a1, a2, a3, s;
		logic [127:0] res;
		rc = 8'h01;
		for (int j = 0; j < 16; j++) rk[j] = key[127 - 8*j -: 8];
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
			if (i % 16 == 0) begin
				f = w[0];
				w[0] = sbox_lut[w[1]] ^ rc;
				w[1] = sbox_lut[w[2]];
				w[2] = sbox_lut[w[3]];
				w[3] = sbox_lut[f];
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end
			for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
		end
		for (int j = 0; j < 16; j++) st[j] = plain[127 - 8*j -: 8] ^ rk[j];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					tmp[c*4 + j] = sbox_lut[st[((c + j) % 4) * 4 + j]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
					s = a0 ^ a1 ^ a2 ^ a3;
					tmp[c*4]   = a0 ^ s ^ gf_mul(a0 ^ a1, 8'h02);
					tmp[c*4+1] = a1 ^ s ^ gf_mul(a1 ^ a2, 8'h02);
					tmp[c*4+2] = a2 ^ s ^ gf_mul(a2 ^ a3, 8'h02);
					tmp[c*4+3] = a3 ^ s ^ gf_mul(a3 ^ a0, 8'h02);
				end
			end
			for (int j = 0; j < 16; j++) st[j] = tmp[j] ^ rk[r*16 + j];
		end
		for (int j = 0; j < 16; j++) res[127 - 8*j -: 8] = st[j];
		return res;
	endfunction

	// Walk the tree from the request's level down to the leaf.
	function automatic prf_key_t derive_leaf_key(input prf_request_t req);
		logic [127:0] k;
		logic [127:0] plain;
		prf_key_t res;
		k = {req.key_hi, req.key_lo};
		for (int unsigned i = req.level; i < DEPTH; i++) begin
			plain = req.tag[31 - i] ? {8{16'h0100}} : {8{16'h0001}};
			k = encrypt_block(k, plain);
		end
		res.hi = k[127:64];
		res.lo = k[63:0];
		return res;
	endfunction

	function automatic prf_request_t rand_request(input int unsigned level);
		prf_request_t r;
		r.key_hi = {$urandom, $urandom};
		r.key_lo = {$urandom, $urandom};
		r.tag    = $urandom;
		r.level  = LevelW'(level);
		return r;
	endfunction

	// Mostly deep-ish levels would be slow; bias toward short walks.
	function automatic int unsigned rand_level();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 3) return $urandom_range(0, 8);
		if (p < 10) return $urandom_range(DEPTH + 1, 63);
		if (p < 18) return DEPTH;
		return $urandom_range(24, DEPTH - 1);
	endfunction

	function automatic int unsigned rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(1, 4);
	endfunction

	// Fill the request queue: directed corners first, then random.
	initial begin
		prf_request_t r;
		r = '{64'h0, 64'h0, 32'h0, 6'd0};
		pending_requests.push_back(r);
		r = '{'1, '1, '1, 6'd0};
		pending_requests.push_back(r);
		r = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 32'hffffffff, 6'd31};
		pending_requests.push_back(r);
		r = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 32'h00000000, 6'd31};
		pending_requests.push_back(r);
		r = '{'1, 64'h0, 32'h5555aaaa, 6'd30};
		pending_requests.push_back(r);
		// Key at the leaf, and levels below the leaf, come back unchanged.
		r = '{64'hdeadbeefcafef00d, 64'h0123456789abcdef, 32'h12345678, 6'd32};
		pending_requests.push_back(r);
		r = '{'1, '1, '1, 6'd33};
		pending_requests.push_back(r);
		r = '{64'h0, 64'h0, 32'h0, 6'd63};
		pending_requests.push_back(r);
		r = '{64'h8000000000000001, 64'h8000000000000001, 32'h80000001, 6'd1};
		pending_requests.push_back(r);
		for (int i = 0; i < 8; i++) pending_requests.push_back(rand_request(16 + 2*i));
		for (int i = 0; i < 1440; i++) pending_requests.push_back(rand_request(rand_level()));
	end

	// Driver: presents one request at a time, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		prf_request_t r;
		if (!arst_n) begin
			start       <= 1'b0;
			key_hi      <= '0;
			key_lo      <= '0;
			tag         <= '0;
			start_level <= '0;
			gap_left    <= 0;
			drain_hold  <= 1'b0;
			stimulus_done <= 1'b0;
		end else if (start && !busy) begin
			// The request was taken at this edge.
			r.key_hi = key_hi; r.key_lo = key_lo; r.tag = tag; r.level = start_level;
			expected_keys.push_back(derive_leaf_key(r));
			if (start_level >= LevelW'(DEPTH)) bottom_level_count <= bottom_level_count + 1;
			start    <= 1'b0;
			gap_left <= rand_gap();
			if (pending_requests.size() == 700) drain_hold <= 1'b1;
		end else if (!start) begin
			if (drain_hold) begin
				if (expected_keys.size() == 0) drain_hold <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() != 0) begin
				r = pending_requests.pop_front();
				start       <= 1'b1;
				key_hi      <= r.key_hi;
				key_lo      <= r.key_lo;
				tag         <= r.tag;
				start_level <= r.level;
			end else begin
				stimulus_done <= 1'b1;
			end
		end
	end

	// Monitor: every done strobe is checked against the oldest expectation.
	always @(posedge clk) begin
		prf_key_t e;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_keys.size() == 0) begin
				$error("unexpected result out_hi=%h out_lo=%h", out_hi, out_lo);
				error_count <= error_count + 1;
			end else begin
				e = expected_keys.pop_front();
				if (out_hi !== e.hi) begin
					$error("out_hi expected %h actual %h", e.hi, out_hi);
					error_count <= error_count + 1;
				end
				if (out_lo !== e.lo) begin
					$error("out_lo expected %h actual %h", e.lo, out_lo);
					error_count <= error_count + 1;
				end
			end
		end
	end

	// End of run: drain, allow the pipeline to settle, then report.
	initial begin
		error_count = 0;
		results_seen = 0;
		cycle_count = 0;
		bottom_level_count = 0;
		fork
			begin
				wait (stimulus_done && expected_keys.size() == 0);
				repeat (400) @(posedge clk);
				if (expected_keys.size() != 0) begin
					$error("%0d results never arrived", expected_keys.size());
					error_count++;
				end
				$display("Checked %0d derived keys, %0d of them from the leaf level or below.",
					results_seen, bottom_level_count);
				if (error_count == 0) begin
					$display("RESULT: OK");
				end else begin
					$display("RESULT: ERROR");
				end
				$finish;
			end
			begin
				while (cycle_count < CYCLE_LIMIT) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("Timed out after %0d cycles.", cycle_count);
				$display("RESULT: ERROR");
				$finish;
			end
		join
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ggm_pkg.sv
hw/rtl/ggm_tree_prf_eval.sv
tb/testbench.sv
